// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked implication checks that drop out of synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: implication check failed");
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");
`else
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// ----- rtl/core/dmrfct_pkg.sv -----
// ----------------------------------------------------------------------------
// dmrfct_pkg
// Shared types, codes and constants of the DMR frame call tracker.
// ----------------------------------------------------------------------------
package dmrfct_pkg;

    localparam int FRAME_COUNT_BITS_DEF = 16;
    localparam int CFG_DATA_W           = 8;
    localparam int LOG_FRAMES_W         = 16;
    localparam int MIN_FRAMES_W         = 8;

    localparam logic [3:0] TERMINATOR_TYPE_RST   = 4'd2;
    localparam logic [7:0] MIN_LOGGED_FRAMES_RST = 8'd2;

    typedef enum logic {
        CFG_TERMINATOR_TYPE   = 1'b0,
        CFG_MIN_LOGGED_FRAMES = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        EV_IGNORED  = 2'd0,
        EV_CONTINUE = 2'd1,
        EV_NEW_CALL = 2'd2,
        EV_CALL_END = 2'd3
    } ev_t;

    localparam logic [5:0] POS_MAX      = 6'd63;
    localparam logic [5:0] POS_TAG_END  = 6'd4;
    localparam logic [5:0] POS_SRC_HI   = 6'd5;
    localparam logic [5:0] POS_SRC_MID  = 6'd6;
    localparam logic [5:0] POS_SRC_LO   = 6'd7;
    localparam logic [5:0] POS_DST_HI   = 6'd8;
    localparam logic [5:0] POS_DST_MID  = 6'd9;
    localparam logic [5:0] POS_DST_LO   = 6'd10;
    localparam logic [5:0] POS_CTL      = 6'd15;
    localparam logic [5:0] POS_MIN_LAST = 6'd19;
    localparam logic [5:0] POS_BER      = 6'd53;
    localparam logic [5:0] POS_RSSI     = 6'd54;

    localparam int CTL_SLOT2_BIT   = 7;
    localparam int CTL_PRIVATE_BIT = 6;
    localparam int CTL_DSYNC_BIT   = 5;

    typedef struct packed {
        logic [3:0] terminator_type;
        logic [7:0] min_logged_frames;
    } cfg_t;

    typedef struct packed {
        logic        pkt_ok;
        logic        has_ber;
        logic        has_rssi;
        logic [23:0] src;
        logic [23:0] dst;
        logic [7:0]  ctl;
        logic [7:0]  ber;
        logic [7:0]  rssi;
    } hdr_t;

    typedef struct packed {
        ev_t         event_res;
        logic        packet_slot;
        logic        log_valid;
        logic        log_slot;
        logic [23:0] log_source;
        logic [23:0] log_destination;
        logic        log_group;
        logic [31:0] log_duration_ms;
        logic [15:0] log_frames;
        logic [7:0]  log_ber;
        logic [7:0]  log_rssi;
    } result_t;

    function automatic logic [7:0] tag_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'h44;
            2'd1:    b = 8'h4D;
            2'd2:    b = 8'h52;
            default: b = 8'h44;
        endcase
        return b;
    endfunction

endpackage

// ----- rtl/core/dmrfct_parser.sv -----
// ----------------------------------------------------------------------------
// dmrfct_parser
// Counts datagram bytes, checks the tag and captures the header fields.
// ----------------------------------------------------------------------------
module dmrfct_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic [7:0]        rx_byte,
    input  logic              eop,
    output dmrfct_pkg::hdr_t  hdr
);

    logic [5:0]  pos_reg, pos_next;
    logic        tag_ok_reg, tag_ok_next;
    logic [23:0] src_reg, src_next;
    logic [23:0] dst_reg, dst_next;
    logic [7:0]  ctl_reg, ctl_next;
    logic [7:0]  ber_reg, ber_next;
    logic [7:0]  rssi_reg, rssi_next;

    always_comb begin
        tag_ok_next = tag_ok_reg;
        src_next    = src_reg;
        dst_next    = dst_reg;
        ctl_next    = ctl_reg;
        ber_next    = ber_reg;
        rssi_next   = rssi_reg;
        if (pos_reg < dmrfct_pkg::POS_TAG_END &&
            rx_byte != dmrfct_pkg::tag_byte(pos_reg[1:0])) begin
            tag_ok_next = 1'b0;
        end
        unique case (pos_reg)
            dmrfct_pkg::POS_SRC_HI:  src_next[23:16] = rx_byte;
            dmrfct_pkg::POS_SRC_MID: src_next[15:8]  = rx_byte;
            dmrfct_pkg::POS_SRC_LO:  src_next[7:0]   = rx_byte;
            dmrfct_pkg::POS_DST_HI:  dst_next[23:16] = rx_byte;
            dmrfct_pkg::POS_DST_MID: dst_next[15:8]  = rx_byte;
            dmrfct_pkg::POS_DST_LO:  dst_next[7:0]   = rx_byte;
            dmrfct_pkg::POS_CTL:     ctl_next        = rx_byte;
            dmrfct_pkg::POS_BER:     ber_next        = rx_byte;
            dmrfct_pkg::POS_RSSI:    rssi_next       = rx_byte;
            default: ;
        endcase
        pos_next = (pos_reg != dmrfct_pkg::POS_MAX) ? pos_reg + 6'd1 : pos_reg;

        hdr.pkt_ok   = tag_ok_next && (pos_reg >= dmrfct_pkg::POS_MIN_LAST);
        hdr.has_ber  = pos_reg >= dmrfct_pkg::POS_BER;
        hdr.has_rssi = pos_reg >= dmrfct_pkg::POS_RSSI;
        hdr.src      = src_next;
        hdr.dst      = dst_next;
        hdr.ctl      = ctl_next;
        hdr.ber      = ber_next;
        hdr.rssi     = rssi_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            tag_ok_reg <= 1'b1;
        end else if (step) begin
            if (eop) begin
                pos_reg    <= '0;
                tag_ok_reg <= 1'b1;
            end else begin
                pos_reg    <= pos_next;
                tag_ok_reg <= tag_ok_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            src_reg  <= src_next;
            dst_reg  <= dst_next;
            ctl_reg  <= ctl_next;
            ber_reg  <= ber_next;
            rssi_reg <= rssi_next;
        end
    end

endmodule

// ----- rtl/core/dmrfct_tracker.sv -----
// ----------------------------------------------------------------------------
// dmrfct_tracker
// Per-slot call records: call start, frame counting, termination and logging.
// ----------------------------------------------------------------------------
module dmrfct_tracker #(
    parameter int FRAME_COUNT_BITS = dmrfct_pkg::FRAME_COUNT_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  dmrfct_pkg::hdr_t    hdr,
    input  logic [31:0]         now_ms,
    input  dmrfct_pkg::cfg_t    cfg,
    output dmrfct_pkg::result_t res
);

    localparam int FCB   = FRAME_COUNT_BITS;
    localparam int CMP_W = (FCB > dmrfct_pkg::MIN_FRAMES_W) ? FCB : dmrfct_pkg::MIN_FRAMES_W;
    localparam int LFW   = dmrfct_pkg::LOG_FRAMES_W;

    logic              active_reg [2];
    logic [23:0]       src_reg    [2];
    logic [23:0]       dst_reg    [2];
    logic              group_reg  [2];
    logic [FCB-1:0]    frames_reg [2];
    logic [31:0]       start_reg  [2];
    logic [7:0]        ber_reg    [2];
    logic [7:0]        rssi_reg   [2];

    logic              s;
    logic              mismatch;
    logic              term;
    logic              log_old;
    logic              log_new;
    logic [CMP_W-1:0]  min_ext;
    logic [FCB-1:0]    frames_base;
    logic [FCB-1:0]    frames_next;
    logic [FCB-1:0]    frames_sel;
    logic [LFW-1:0]    frames_log;
    logic              group_next;
    logic [31:0]       start_next;
    logic [7:0]        ber_next;
    logic [7:0]        rssi_next;

    generate
        if (FCB >= LFW) begin : g_frames_trunc
            assign frames_log = frames_sel[LFW-1:0];
        end else begin : g_frames_ext
            assign frames_log = {{(LFW-FCB){1'b0}}, frames_sel};
        end
    endgenerate

    always_comb begin
        s        = hdr.ctl[dmrfct_pkg::CTL_SLOT2_BIT];
        min_ext  = CMP_W'(cfg.min_logged_frames);
        mismatch = !active_reg[s] || (src_reg[s] != hdr.src) || (dst_reg[s] != hdr.dst);
        log_old  = mismatch && active_reg[s] && (CMP_W'(frames_reg[s]) > min_ext);

        frames_base = mismatch ? '0 : frames_reg[s];
        frames_next = (frames_base != {FCB{1'b1}}) ? frames_base + FCB'(1) : frames_base;
        group_next  = mismatch ? !hdr.ctl[dmrfct_pkg::CTL_PRIVATE_BIT] : group_reg[s];
        start_next  = mismatch ? now_ms : start_reg[s];
        ber_next    = hdr.has_ber ? hdr.ber : (mismatch ? 8'd0 : ber_reg[s]);
        rssi_next   = hdr.has_rssi ? hdr.rssi : (mismatch ? 8'd0 : rssi_reg[s]);

        term    = hdr.ctl[dmrfct_pkg::CTL_DSYNC_BIT] && (hdr.ctl[3:0] == cfg.terminator_type);
        log_new = term && !log_old && (CMP_W'(frames_next) > min_ext);
        frames_sel = log_old ? frames_reg[s] : frames_next;

        res = '0;
        if (hdr.pkt_ok) begin
            if (term) begin
                res.event_res = dmrfct_pkg::EV_CALL_END;
            end else if (mismatch) begin
                res.event_res = dmrfct_pkg::EV_NEW_CALL;
            end else begin
                res.event_res = dmrfct_pkg::EV_CONTINUE;
            end
            res.packet_slot = s;
            if (log_old || log_new) begin
                res.log_valid       = 1'b1;
                res.log_slot        = s;
                res.log_source      = log_old ? src_reg[s] : hdr.src;
                res.log_destination = log_old ? dst_reg[s] : hdr.dst;
                res.log_group       = log_old ? group_reg[s] : group_next;
                res.log_duration_ms = now_ms - (log_old ? start_reg[s] : start_next);
                res.log_frames      = frames_log;
                res.log_ber         = log_old ? ber_reg[s] : ber_next;
                res.log_rssi        = log_old ? rssi_reg[s] : rssi_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg[0] <= 1'b0;
            active_reg[1] <= 1'b0;
        end else if (step && hdr.pkt_ok) begin
            active_reg[s] <= !term;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && hdr.pkt_ok) begin
            src_reg[s]    <= hdr.src;
            dst_reg[s]    <= hdr.dst;
            group_reg[s]  <= group_next;
            frames_reg[s] <= frames_next;
            start_reg[s]  <= start_next;
            ber_reg[s]    <= ber_next;
            rssi_reg[s]   <= rssi_next;
        end
    end

endmodule

// ----- rtl/core/dmr_frame_call_tracker.sv -----
// ----------------------------------------------------------------------------
// dmr_frame_call_tracker
// Parses DMR network datagrams byte by byte and tracks calls per time slot.
// ----------------------------------------------------------------------------
// Usage:
// Datagram bytes enter on the s_ channel, one item per byte, with
// s_end_of_packet set on the last byte and s_now_ms sampled with it.
// Each last byte yields exactly one result item on the m_ channel; other
// bytes yield none. A result carries the packet's event and slot and, when
// a call closed with enough frames, its log record (log fields are zero
// otherwise).
// Throughput is one item per cycle while no last byte waits on a stalled
// receiver. A byte is registered, then the parser and the slot record
// read-modify-write finish it. Results reach m_valid from the output register.
// When the receiver stalls, the result holds in the output register and
// plain bytes keep flowing; a further last byte waits in the input stage,
// after which s_ready drops.
// Reset clears the byte position, the tag check and both slot trackers and
// loads the register defaults (terminator type 2, minimum logged frames 2).
// Registers are written through cfg_wr_en, cfg_index and cfg_wdata, by a user
// bound to do so only while no datagram is in flight; the block has no check.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dmr_frame_call_tracker #(
    parameter int FRAME_COUNT_BITS = dmrfct_pkg::FRAME_COUNT_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic                              cfg_index,
    input  logic [dmrfct_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [7:0]                        s_rx_byte,
    input  logic                              s_end_of_packet,
    input  logic [31:0]                       s_now_ms,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [1:0]                        m_event_res,
    output logic                              m_packet_slot,
    output logic                              m_log_valid,
    output logic                              m_log_slot,
    output logic [23:0]                       m_log_source,
    output logic [23:0]                       m_log_destination,
    output logic                              m_log_group,
    output logic [31:0]                       m_log_duration_ms,
    output logic [15:0]                       m_log_frames,
    output logic [7:0]                        m_log_ber,
    output logic [7:0]                        m_log_rssi
);

    dmrfct_pkg::cfg_t    cfg_reg;
    dmrfct_pkg::hdr_t    hdr;
    dmrfct_pkg::result_t res;
    dmrfct_pkg::result_t res_reg;

    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_eop_reg;
    logic [31:0] s1_now_reg;
    logic        out_valid_reg;
    logic        out_free;
    logic        s1_adv;
    logic        log_ev_ok;
    logic        ev_ignored;
    logic        eop_blocked;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.terminator_type   <= dmrfct_pkg::TERMINATOR_TYPE_RST;
            cfg_reg.min_logged_frames <= dmrfct_pkg::MIN_LOGGED_FRAMES_RST;
        end else if (cfg_wr_en) begin
            unique case (dmrfct_pkg::cfg_idx_t'(cfg_index))
                dmrfct_pkg::CFG_TERMINATOR_TYPE:   cfg_reg.terminator_type <= cfg_wdata[3:0];
                dmrfct_pkg::CFG_MIN_LOGGED_FRAMES: cfg_reg.min_logged_frames <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign out_free = !out_valid_reg || m_ready;
    assign s1_adv   = s1_valid_reg && (!s1_eop_reg || out_free);
    assign s_ready  = !s1_valid_reg || s1_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            s1_byte_reg <= s_rx_byte;
            s1_eop_reg  <= s_end_of_packet;
            s1_now_reg  <= s_now_ms;
        end
    end

    dmrfct_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (s1_adv),
        .rx_byte (s1_byte_reg),
        .eop     (s1_eop_reg),
        .hdr     (hdr)
    );

    dmrfct_tracker #(
        .FRAME_COUNT_BITS (FRAME_COUNT_BITS)
    ) u_tracker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (s1_adv && s1_eop_reg),
        .hdr     (hdr),
        .now_ms  (s1_now_reg),
        .cfg     (cfg_reg),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= s1_adv && s1_eop_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv && s1_eop_reg) begin
            res_reg <= res;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_event_res       = res_reg.event_res;
    assign m_packet_slot     = res_reg.packet_slot;
    assign m_log_valid       = res_reg.log_valid;
    assign m_log_slot        = res_reg.log_slot;
    assign m_log_source      = res_reg.log_source;
    assign m_log_destination = res_reg.log_destination;
    assign m_log_group       = res_reg.log_group;
    assign m_log_duration_ms = res_reg.log_duration_ms;
    assign m_log_frames      = res_reg.log_frames;
    assign m_log_ber         = res_reg.log_ber;
    assign m_log_rssi        = res_reg.log_rssi;

    assign log_ev_ok   = (m_event_res == dmrfct_pkg::EV_NEW_CALL) ||
                         (m_event_res == dmrfct_pkg::EV_CALL_END);
    assign ev_ignored  = m_valid && (m_event_res == dmrfct_pkg::EV_IGNORED);
    assign eop_blocked = s1_valid_reg && s1_eop_reg && out_valid_reg && !m_ready;

    `ASSERT_IMPLIES(a_log_needs_call_change, aclk, aresetn, m_valid && m_log_valid, log_ev_ok)
    `ASSERT_IMPLIES(a_ignored_is_empty, aclk, aresetn, ev_ignored, !m_log_valid && !m_packet_slot)
    `ASSERT_NEXT(a_last_byte_waits, aclk, aresetn, eop_blocked, s1_valid_reg)

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Feeds DMR network datagrams into the call tracker one byte per item and
// checks every result item against a cycle-free model of the parser and
// both slot trackers that the bench keeps itself. Directed datagrams cover
// rejected packets, optional BER/RSSI bytes, over-long datagrams, wrapped
// durations and calls that close two ways at once. Random traffic then runs
// under several register settings with random stalls on both channels, a
// long output hold-off and a stretch without any idle cycles.
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic [31:0] DMRD_TAG = 32'h444D_5244;
    localparam logic [15:0] FRAMES_SAT = 16'hFFFF;
    localparam int IDLE_PCT = 18;
    localparam int CALL_HOLD_CYCLES = 400;
    localparam int QUIET_LIMIT = 4000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_index = 1'b0;
    logic [7:0]  cfg_wdata = 8'h00;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        s_end_of_packet = 1'b0;
    logic [31:0] s_now_ms = 32'h0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_event_res;
    logic        m_packet_slot;
    logic        m_log_valid;
    logic        m_log_slot;
    logic [23:0] m_log_source;
    logic [23:0] m_log_destination;
    logic        m_log_group;
    logic [31:0] m_log_duration_ms;
    logic [15:0] m_log_frames;
    logic [7:0]  m_log_ber;
    logic [7:0]  m_log_rssi;

    logic [3:0]  term_type;
    logic [7:0]  min_frames;
    logic [5:0]  rx_pos;
    logic        tag_match;
    logic [23:0] hdr_src;
    logic [23:0] hdr_dst;
    logic [7:0]  hdr_ctl;
    logic [7:0]  hdr_ber;
    logic [7:0]  hdr_rssi;
    logic        call_active [2];
    logic [23:0] call_src [2];
    logic [23:0] call_dst [2];
    logic        call_group [2];
    logic [15:0] call_frames [2];
    logic [31:0] call_start [2];
    logic [7:0]  call_ber [2];
    logic [7:0]  call_rssi [2];

    dmrfct_pkg::result_t pending_results [$];
    dmrfct_pkg::result_t want;
    int          mismatches = 0;
    int          bytes_sent = 0;
    int          results_predicted = 0;
    int          quiet_cycles = 0;
    int          hold_count = 0;
    bit          no_idle = 1'b0;
    bit          long_hold = 1'b0;
    bit          long_hold_done = 1'b0;
    logic [31:0] clock_ms;
    logic [23:0] src_pool [3];
    logic [23:0] dst_pool [3];
    int          pair_src [2];
    int          pair_dst [2];

    dmr_frame_call_tracker dut (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    task automatic clear_capture();
        rx_pos = '0;
        tag_match = 1'b1;
        hdr_src = '0;
        hdr_dst = '0;
        hdr_ctl = '0;
        hdr_ber = '0;
        hdr_rssi = '0;
    endtask

    task automatic clear_call(input int s);
        call_active[s] = 1'b0;
        call_src[s] = '0;
        call_dst[s] = '0;
        call_group[s] = 1'b0;
        call_frames[s] = '0;
        call_start[s] = '0;
        call_ber[s] = '0;
        call_rssi[s] = '0;
    endtask

    task automatic reset_tracker();
        term_type = dmrfct_pkg::TERMINATOR_TYPE_RST;
        min_frames = dmrfct_pkg::MIN_LOGGED_FRAMES_RST;
        clear_capture();
        clear_call(0);
        clear_call(1);
    endtask

    task automatic record_call(inout dmrfct_pkg::result_t r, input int s,
                               input logic [31:0] now);
        r.log_valid = 1'b1;
        r.log_slot = s[0];
        r.log_source = call_src[s];
        r.log_destination = call_dst[s];
        r.log_group = call_group[s];
        r.log_duration_ms = now - call_start[s];
        r.log_frames = call_frames[s];
        r.log_ber = call_ber[s];
        r.log_rssi = call_rssi[s];
    endtask

    // Advances the parser by one accepted byte and, on the last byte of a
    // datagram, queues the result item that the packet must produce.
    task automatic track_byte(input logic [7:0] b, input logic eop, input logic [31:0] now);
        int p;
        int len;
        int s;
        logic [7:0] ctl;
        logic logged;
        dmrfct_pkg::result_t r;
        p = rx_pos;
        if (p < 4) begin
            if (b != DMRD_TAG[31 - 8 * p -: 8]) tag_match = 1'b0;
        end
        case (p)
            5: hdr_src[23:16] = b;
            6: hdr_src[15:8] = b;
            7: hdr_src[7:0] = b;
            8: hdr_dst[23:16] = b;
            9: hdr_dst[15:8] = b;
            10: hdr_dst[7:0] = b;
            15: hdr_ctl = b;
            53: hdr_ber = b;
            54: hdr_rssi = b;
            default: ;
        endcase
        if (rx_pos != 6'd63) rx_pos = rx_pos + 6'd1;
        if (eop) begin
            r = '0;
            len = p + 1;
            if (tag_match && len >= 20) begin
                ctl = hdr_ctl;
                s = ctl[7];
                logged = 1'b0;
                r.event_res = dmrfct_pkg::EV_CONTINUE;
                if (!call_active[s] || call_src[s] != hdr_src || call_dst[s] != hdr_dst) begin
                    if (call_active[s] && call_frames[s] > min_frames) begin
                        record_call(r, s, now);
                        logged = 1'b1;
                    end
                    clear_call(s);
                    call_src[s] = hdr_src;
                    call_dst[s] = hdr_dst;
                    call_group[s] = !ctl[6];
                    call_start[s] = now;
                    call_active[s] = 1'b1;
                    r.event_res = dmrfct_pkg::EV_NEW_CALL;
                end
                if (call_frames[s] != FRAMES_SAT) call_frames[s] = call_frames[s] + 16'd1;
                if (len >= 54) call_ber[s] = hdr_ber;
                if (len >= 55) call_rssi[s] = hdr_rssi;
                if (ctl[5] && ctl[3:0] == term_type) begin
                    if (!logged && call_frames[s] > min_frames) record_call(r, s, now);
                    clear_call(s);
                    r.event_res = dmrfct_pkg::EV_CALL_END;
                end
                r.packet_slot = s[0];
            end
            pending_results.push_back(r);
            results_predicted++;
            clear_capture();
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic eop, input logic [31:0] now);
        if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < IDLE_PCT);
        end
        s_valid <= 1'b1;
        s_rx_byte <= b;
        s_end_of_packet <= eop;
        s_now_ms <= now;
        do @(posedge aclk); while (!s_ready);
        track_byte(b, eop, now);
        bytes_sent++;
    endtask

    task automatic send_datagram(input int len, input logic [23:0] src, input logic [23:0] dst,
                                 input logic [7:0] ctl, input logic [31:0] now, input bit tag_bad,
                                 input logic [7:0] ber, input logic [7:0] rssi);
        int i;
        int bad_pos;
        logic [7:0] b;
        bad_pos = tag_bad ? $urandom_range(((len < 4) ? len : 4) - 1) : -1;
        for (i = 0; i < len; i++) begin
            b = 8'($urandom);
            if (i < 4) b = DMRD_TAG[31 - 8 * i -: 8];
            if (i == bad_pos) b = b ^ 8'($urandom_range(255, 1));
            case (i)
                5: b = src[23:16];
                6: b = src[15:8];
                7: b = src[7:0];
                8: b = dst[23:16];
                9: b = dst[15:8];
                10: b = dst[7:0];
                15: b = ctl;
                53: b = ber;
                54: b = rssi;
                default: ;
            endcase
            send_byte(b, i == len - 1, (i == len - 1) ? now : $urandom);
        end
    endtask

    function automatic logic [7:0] make_ctl(input logic slot2, input logic priv,
                                            input logic dsync, input logic [3:0] ftype);
        return {slot2, priv, dsync, 1'b0, ftype};
    endfunction

    // Mostly well-formed packets that keep a call going on each slot, with
    // some short noise, broken tags and occasional jumps of the time base.
    task automatic send_random_datagram();
        int kind;
        int len;
        int s;
        logic dsync;
        logic [3:0] ftype;
        logic [7:0] ctl;
        kind = $urandom_range(99);
        s = $urandom_range(1);
        if ($urandom_range(99) < 12) begin
            pair_src[s] = $urandom_range(2);
            pair_dst[s] = $urandom_range(2);
        end
        if ($urandom_range(99) < 10) begin
            dsync = 1'b1;
            ftype = term_type;
        end else begin
            dsync = ($urandom_range(99) < 30);
            ftype = 4'($urandom);
        end
        ctl = {s[0], 1'($urandom), dsync, 1'($urandom), ftype};
        if ($urandom_range(99) < 3) clock_ms = $urandom;
        else clock_ms = clock_ms + $urandom_range(1000);
        if (kind < 8) len = $urandom_range(19, 1);
        else if (kind < 85) len = $urandom_range(24, 20);
        else if (kind < 95) len = $urandom_range(56, 53);
        else len = $urandom_range(70, 57);
        send_datagram(len, src_pool[pair_src[s]], dst_pool[pair_dst[s]], ctl, clock_ms,
                      $urandom_range(99) < 6, 8'($urandom), 8'($urandom));
    endtask

    task automatic wait_results_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic configure(input logic [7:0] term_word, input logic [7:0] min_word);
        wait_results_drained();
        cfg_wr_en <= 1'b1;
        cfg_index <= dmrfct_pkg::CFG_TERMINATOR_TYPE;
        cfg_wdata <= term_word;
        @(posedge aclk);
        cfg_index <= dmrfct_pkg::CFG_MIN_LOGGED_FRAMES;
        cfg_wdata <= min_word;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        term_type = term_word[3:0];
        min_frames = min_word;
    endtask

    task automatic run_random_traffic(input int byte_goal, input int result_goal);
        int bytes0;
        int results0;
        bytes0 = bytes_sent;
        results0 = results_predicted;
        while (bytes_sent - bytes0 < byte_goal || results_predicted - results0 < result_goal)
            send_random_datagram();
    endtask

    task automatic test_default_call();
        send_datagram(20, 24'hFFFFFF, 24'h000001, make_ctl(1, 1, 0, 4'd2), 32'hFFFF_FF00,
                      0, 8'h00, 8'h00);
        send_datagram(24, 24'hFFFFFF, 24'h000001, make_ctl(1, 1, 0, 4'd7), 32'hFFFF_FF80,
                      0, 8'h00, 8'h00);
        send_datagram(55, 24'hFFFFFF, 24'h000001, make_ctl(1, 0, 1, 4'd15), 32'hFFFF_FFF0,
                      0, 8'hFF, 8'h00);
        send_datagram(20, 24'hFFFFFF, 24'h000001, make_ctl(1, 1, 1, 4'd2), 32'h0000_0040,
                      0, 8'h00, 8'h00);
    endtask

    task automatic test_rejected_datagrams();
        send_datagram(1, 24'h0, 24'h0, 8'h00, $urandom, 0, 8'h00, 8'h00);
        send_datagram(3, 24'h0, 24'h0, 8'h00, $urandom, 0, 8'h00, 8'h00);
        send_datagram(19, 24'h111111, 24'h222222, make_ctl(0, 0, 0, 4'd1), $urandom,
                      0, 8'h00, 8'h00);
        send_datagram(20, 24'h111111, 24'h222222, make_ctl(0, 0, 0, 4'd1), $urandom,
                      1, 8'h00, 8'h00);
        send_datagram(3, 24'h0, 24'h0, 8'h00, $urandom, 1, 8'h00, 8'h00);
    endtask

    task automatic test_ber_rssi_and_long();
        send_datagram(54, 24'h123456, 24'hABCDEF, make_ctl(0, 0, 0, 4'd0), 32'h0000_1000,
                      0, 8'h5A, 8'hA5);
        send_datagram(70, 24'h123456, 24'hABCDEF, make_ctl(0, 1, 0, 4'd3), 32'h0000_1100,
                      0, 8'h00, 8'hFF);
        send_datagram(64, 24'h123456, 24'hABCDEF, make_ctl(0, 0, 1, 4'd3), 32'h0000_1200,
                      0, 8'hC3, 8'h3C);
        send_datagram(20, 24'h123456, 24'hABCDEF, make_ctl(0, 0, 1, 4'd2), 32'h0000_1300,
                      0, 8'h00, 8'h00);
    endtask

    task automatic test_terminator_on_new_call();
        send_datagram(21, 24'h000000, 24'hFFFFFF, make_ctl(0, 1, 1, 4'd2), 32'h8000_0000,
                      0, 8'h00, 8'h00);
        send_datagram(55, 24'h00FF00, 24'hFF00FF, make_ctl(1, 0, 1, 4'd2), 32'h8000_0001,
                      0, 8'h77, 8'h88);
    endtask

    task automatic test_two_records_extremes();
        configure(8'h0F, 8'h00);
        send_datagram(20, 24'h0A0B0C, 24'h0D0E0F, make_ctl(0, 0, 0, 4'd0), 32'h0001_0000,
                      0, 8'h00, 8'h00);
        send_datagram(55, 24'h0A0B0C, 24'h0D0E0F, make_ctl(0, 0, 0, 4'd0), 32'h0001_0010,
                      0, 8'h12, 8'h34);
        send_datagram(20, 24'h0A0B0D, 24'h0D0E0F, make_ctl(0, 1, 1, 4'd15), 32'h0001_0020,
                      0, 8'h00, 8'h00);
        configure(8'hF0, 8'hFF);
        send_datagram(20, 24'h505050, 24'h606060, make_ctl(1, 0, 0, 4'd0), 32'h0002_0000,
                      0, 8'h00, 8'h00);
        send_datagram(20, 24'h505050, 24'h606060, make_ctl(1, 0, 0, 4'd1), 32'h0002_0010,
                      0, 8'h00, 8'h00);
        send_datagram(20, 24'h505050, 24'h606060, make_ctl(1, 0, 1, 4'd0), 32'h0002_0020,
                      0, 8'h00, 8'h00);
    endtask

    task automatic test_random_phases();
        configure(8'h00, 8'h00);
        run_random_traffic(80, 3);
        configure(8'hFF, 8'hFF);
        run_random_traffic(80, 3);
        configure(8'($urandom), 8'($urandom_range(5)));
        run_random_traffic(80, 3);
        configure(8'h02, 8'h02);
        run_random_traffic(80, 3);
    endtask

    task automatic test_output_backpressure();
        long_hold_done = 1'b0;
        long_hold = 1'b1;
        repeat (8) send_random_datagram();
        wait_results_drained();
        long_hold = 1'b0;
    endtask

    task automatic test_no_idle_burst();
        no_idle = 1'b1;
        run_random_traffic(150, 0);
        wait_results_drained();
        no_idle = 1'b0;
    endtask

    always @(posedge aclk) begin
        if (long_hold && !long_hold_done) begin
            m_ready <= 1'b0;
            hold_count = hold_count + 1;
            if (hold_count == CALL_HOLD_CYCLES) begin
                long_hold_done = 1'b1;
                hold_count = 0;
            end
        end else begin
            m_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (act_val !== exp_val) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result item with no packet waiting for it");
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("event_res", want.event_res, m_event_res);
                check_field("packet_slot", want.packet_slot, m_packet_slot);
                check_field("log_valid", want.log_valid, m_log_valid);
                check_field("log_slot", want.log_slot, m_log_slot);
                check_field("log_source", want.log_source, m_log_source);
                check_field("log_destination", want.log_destination, m_log_destination);
                check_field("log_group", want.log_group, m_log_group);
                check_field("log_duration_ms", want.log_duration_ms, m_log_duration_ms);
                check_field("log_frames", want.log_frames, m_log_frames);
                check_field("log_ber", want.log_ber, m_log_ber);
                check_field("log_rssi", want.log_rssi, m_log_rssi);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
        else quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        reset_tracker();
        src_pool[0] = 24'hFFFFFF;
        src_pool[1] = 24'($urandom);
        src_pool[2] = 24'($urandom);
        dst_pool[0] = 24'h000000;
        dst_pool[1] = 24'($urandom);
        dst_pool[2] = 24'($urandom);
        pair_src[0] = 0;
        pair_src[1] = 1;
        pair_dst[0] = 1;
        pair_dst[1] = 2;
        clock_ms = $urandom;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_default_call();
        test_rejected_datagrams();
        test_ber_rssi_and_long();
        test_terminator_on_new_call();
        test_two_records_extremes();
        test_random_phases();
        test_output_backpressure();
        test_no_idle_burst();
        wait_results_drained();
        repeat (20) @(posedge aclk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- dmr_frame_call_tracker.f -----
+incdir+rtl/core
rtl/core/dmrfct_pkg.sv
rtl/core/dmrfct_parser.sv
rtl/core/dmrfct_tracker.sv
rtl/core/dmr_frame_call_tracker.sv
tb/sv/tb_top.sv
